// ===== sv/rlpc_pkg.sv =====
// Package for the return landing pad checker: word types, status codes,
// table geometry and controller/datapath interface structs. No dependencies.
package rlpc_pkg;

	// table depth is a power of two; slot arithmetic wraps at IDX_W bits
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 64;
	localparam int POS_W       = 7;
	localparam int LEN_W       = 3;
	localparam int TOTAL_W     = 32;

	localparam logic [ADDR_W-1:0] LONG_CALL_LEN  = ADDR_W'(5);
	localparam logic [ADDR_W-1:0] SHORT_CALL_LEN = ADDR_W'(2);

	localparam logic CMD_CALL = 1'b0;
	localparam logic CMD_RET  = 1'b1;

	localparam logic [1:0] ST_CALL    = 2'd0;
	localparam logic [1:0] ST_DROP    = 2'd1;
	localparam logic [1:0] ST_MATCH   = 2'd2;
	localparam logic [1:0] ST_VIOLATE = 2'd3;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] call_site;
		logic [ADDR_W-1:0] return_addr;
	} item_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [POS_W-1:0]   match_position;
		logic [LEN_W-1:0]   call_length;
		logic [TOTAL_W-1:0] match_count;
	} result_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] site;
		logic [ADDR_W-1:0] ret;
	} entry_t;

	typedef struct packed {
		logic store_call;
		logic start_ret;
		logic search;
		logic shift;
		logic commit;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_ret;
		logic empty;
		logic hit;
		logic miss_last;
		logic shift_end;
	} dp_stat_t;

endpackage

// ===== sv/rlpc_ctrl.sv =====
// Controller FSM for the return landing pad checker.
// Depends on rlpc_pkg; drives rlpc_datapath through ctrl_cmd_t.
module rlpc_ctrl import rlpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;
	localparam logic [1:0] S_FIN    = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (stat.is_ret) begin
						cmd.start_ret = 1'b1;
						state_d       = stat.empty ? S_FIN : S_SEARCH;
					end else begin
						cmd.store_call = 1'b1;
						state_d        = S_FIN;
					end
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.hit) begin
					state_d = S_SHIFT;
				end else if (stat.miss_last) begin
					state_d = S_FIN;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.shift_end) begin
					cmd.commit = 1'b1;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/rlpc_datapath.sv =====
// Datapath for the return landing pad checker: call table memory, search
// and compaction pointers, counters and result register. Depends on rlpc_pkg.
module rlpc_datapath import rlpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  item_word_t   item,
	input  ctrl_cmd_t    cmd,
	output dp_stat_t     stat,
	output result_word_t result
);

	entry_t              mem_q [TABLE_DEPTH];
	entry_t              rd_data_q;
	logic [IDX_W-1:0]    rd_addr;
	logic                we;
	logic [IDX_W-1:0]    wa;
	entry_t              wd;

	logic [IDX_W-1:0]    newest_q;
	logic [CNT_W-1:0]    count_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [ADDR_W-1:0]   addr_q, m5_q, m2_q;
	logic [CNT_W-1:0]    k_q;
	logic                cmp_v_q;
	logic [IDX_W-1:0]    cmp_k_q;
	logic [IDX_W-1:0]    j_q;
	logic                wr_pend_q;
	logic [IDX_W-1:0]    wr_slot_q;

	logic [1:0]          res_status_q;
	logic [POS_W-1:0]    res_pos_q;
	logic [LEN_W-1:0]    res_len_q;
	result_word_t        result_q;

	logic                eq_ret, eq5, eq2, match, full;

	assign full   = (count_q == CNT_W'(TABLE_DEPTH));
	assign eq_ret = (rd_data_q.ret == addr_q);
	assign eq5    = (rd_data_q.site == m5_q);
	assign eq2    = (rd_data_q.site == m2_q);
	assign match  = eq_ret && (eq5 || eq2);

	assign stat.is_ret    = (item.cmd == CMD_RET);
	assign stat.empty     = (count_q == '0);
	assign stat.hit       = cmp_v_q && match;
	assign stat.miss_last = cmp_v_q && !match
		&& ({1'b0, cmp_k_q} == count_q - CNT_W'(1));
	assign stat.shift_end = (j_q == '0);

	assign rd_addr = cmd.shift ? (newest_q - j_q + IDX_W'(1))
	                           : (newest_q - k_q[IDX_W-1:0]);

	assign we = cmd.store_call || wr_pend_q;
	assign wa = cmd.store_call ? (newest_q + IDX_W'(1)) : wr_slot_q;
	assign wd = cmd.store_call ? entry_t'{site: item.call_site, ret: item.return_addr}
	                           : rd_data_q;

	// table storage: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
		if (we) begin
			mem_q[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_ret) begin
			addr_q <= item.return_addr;
			m5_q   <= item.return_addr - LONG_CALL_LEN;
			m2_q   <= item.return_addr - SHORT_CALL_LEN;
		end
		cmp_k_q <= k_q[IDX_W-1:0];
		if (cmd.shift) begin
			wr_slot_q <= newest_q - j_q;
		end
		if (cmd.search && stat.hit) begin
			j_q <= cmp_k_q;
		end else if (cmd.shift && j_q != '0) begin
			j_q <= j_q - IDX_W'(1);
		end
		if (cmd.store_call) begin
			res_status_q <= full ? ST_DROP : ST_CALL;
			res_pos_q    <= '0;
			res_len_q    <= '0;
		end else if (cmd.start_ret) begin
			res_status_q <= ST_VIOLATE;
			res_pos_q    <= '0;
			res_len_q    <= '0;
		end else if (cmd.search && stat.hit) begin
			res_status_q <= ST_MATCH;
			res_pos_q    <= POS_W'({1'b0, cmp_k_q} + CNT_W'(1));
			res_len_q    <= eq5 ? LEN_W'(LONG_CALL_LEN) : LEN_W'(SHORT_CALL_LEN);
		end
		if (cmd.load_out) begin
			result_q <= '{status: res_status_q, match_position: res_pos_q,
			              call_length: res_len_q, match_count: total_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q  <= '0;
			count_q   <= '0;
			total_q   <= '0;
			k_q       <= '0;
			cmp_v_q   <= 1'b0;
			wr_pend_q <= 1'b0;
		end else begin
			cmp_v_q   <= cmd.search && (k_q < count_q);
			wr_pend_q <= cmd.shift && (j_q != '0);
			if (cmd.start_ret) begin
				k_q <= '0;
			end else if (cmd.search && k_q < count_q) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (cmd.store_call) begin
				newest_q <= newest_q + IDX_W'(1);
				if (!full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (cmd.commit) begin
				newest_q <= newest_q - IDX_W'(1);
				count_q  <= count_q - CNT_W'(1);
				if (total_q != '1) begin
					total_q <= total_q + TOTAL_W'(1);
				end
			end
		end
	end

	assign result = result_q;

endmodule

// ===== sv/return_landing_pad_checker_top.sv =====
// Return landing pad checker, top level: joins controller and datapath.
// Depends on rlpc_pkg, rlpc_ctrl and rlpc_datapath.
//
// One word in, one result word out, one word at a time. A call passes from
// accept through the final state into the result register. A return searches
// the recorded calls newest first, one table entry per cycle through the
// registered read port of the call table, then closes the gap by copying each
// younger entry one slot older, one entry per cycle on the same port. The
// result register lets the next word be accepted while a result waits.
module return_landing_pad_checker_top import rlpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  item_word_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rlpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	rlpc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	a_match_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_MATCH |->
			result.match_position != '0
			&& (result.call_length == 3'd5 || result.call_length == 3'd2))
		else $error("matched result with bad position or length");

	a_nomatch_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_MATCH |->
			result.match_position == '0 && result.call_length == '0)
		else $error("unmatched result carries position or length");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("word accepted on back-to-back cycles");

	a_commit_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> cmd.shift && stat.shift_end)
		else $error("table commit outside end of compaction");

endmodule
